/* rtl/pwin_pkg.sv */
package pwin_pkg;

	// counter step per tick word, in ms
	localparam logic [31:0] TICK_STEP_MS = 32'd10;

	// configuration register indexes
	localparam logic [1:0] REG_UPPER_LIMIT = 2'd0;
	localparam logic [1:0] REG_LOWER_LIMIT = 2'd1;
	localparam logic [1:0] REG_AUTO_TRIG   = 2'd2;
	localparam logic [1:0] REG_AUTO_BLOCK  = 2'd3;

	// register reset values
	localparam logic [15:0] UPPER_LIMIT_RST = 16'hFFFF;
	localparam logic [15:0] LOWER_LIMIT_RST = 16'h0000;
	localparam logic [15:0] AUTO_TRIG_RST   = 16'd300;
	localparam logic [15:0] AUTO_BLOCK_RST  = 16'd5000;

	// opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// button codes
	localparam logic [1:0] BTN_RELEASED = 2'd0;
	localparam logic [1:0] BTN_UP       = 2'd1;
	localparam logic [1:0] BTN_DOWN     = 2'd2;

	// external state codes
	localparam logic [2:0] CODE_UNINIT  = 3'd0;
	localparam logic [2:0] CODE_IDLE    = 3'd1;
	localparam logic [2:0] CODE_MAN_UP  = 3'd2;
	localparam logic [2:0] CODE_MAN_DN  = 3'd3;
	localparam logic [2:0] CODE_AUTO_UP = 3'd4;
	localparam logic [2:0] CODE_AUTO_DN = 3'd5;
	localparam logic [2:0] CODE_PINCH   = 3'd6;
	localparam logic [2:0] CODE_FAULT   = 3'd7;

	typedef enum logic [7:0] {
		ST_UNINIT  = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_MAN_UP  = 8'b0000_0100,
		ST_MAN_DN  = 8'b0000_1000,
		ST_AUTO_UP = 8'b0001_0000,
		ST_AUTO_DN = 8'b0010_0000,
		ST_PINCH   = 8'b0100_0000,
		ST_FAULT   = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [15:0] upper_position_limit;
		logic [15:0] lower_position_limit;
		logic [15:0] auto_trigger_ms;
		logic [15:0] auto_up_block_ms;
	} cfg_t;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  button;
		logic [15:0] position;
		logic [15:0] press_time_ms;
		logic        learn_done;
		logic        pinch_active;
		logic [2:0]  requested_state;
	} item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] prior_mode;
		logic       accepts_command;
		logic       moving;
	} result_t;

	// state code to one-hot state
	function automatic mode_t mode_decode(input logic [2:0] code);
		mode_t m;
		unique case (code)
			CODE_UNINIT:  m = ST_UNINIT;
			CODE_IDLE:    m = ST_IDLE;
			CODE_MAN_UP:  m = ST_MAN_UP;
			CODE_MAN_DN:  m = ST_MAN_DN;
			CODE_AUTO_UP: m = ST_AUTO_UP;
			CODE_AUTO_DN: m = ST_AUTO_DN;
			CODE_PINCH:   m = ST_PINCH;
			default:      m = ST_FAULT;
		endcase
		return m;
	endfunction

	// one-hot state to state code
	function automatic logic [2:0] mode_encode(input mode_t m);
		logic [2:0] code;
		unique case (m)
			ST_UNINIT:  code = CODE_UNINIT;
			ST_IDLE:    code = CODE_IDLE;
			ST_MAN_UP:  code = CODE_MAN_UP;
			ST_MAN_DN:  code = CODE_MAN_DN;
			ST_AUTO_UP: code = CODE_AUTO_UP;
			ST_AUTO_DN: code = CODE_AUTO_DN;
			ST_PINCH:   code = CODE_PINCH;
			default:    code = CODE_FAULT;
		endcase
		return code;
	endfunction

	// legal-transition table for external requests
	function automatic logic legal_move(input mode_t from, input mode_t to);
		logic ok;
		if (from == to) begin
			ok = 1'b0;
		end else if (to == ST_FAULT) begin
			ok = 1'b1;
		end else begin
			unique case (from)
				ST_FAULT, ST_UNINIT: ok = (to == ST_IDLE);
				ST_IDLE: ok = (to == ST_MAN_UP) || (to == ST_MAN_DN) ||
					(to == ST_AUTO_UP) || (to == ST_AUTO_DN);
				ST_MAN_UP, ST_AUTO_UP: ok = (to == ST_IDLE) || (to == ST_PINCH);
				default: ok = (to == ST_IDLE);
			endcase
		end
		return ok;
	endfunction

endpackage

/* rtl/pwin_cfg.sv */
module pwin_cfg
	import pwin_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_position_limit <= UPPER_LIMIT_RST;
			cfg_q.lower_position_limit <= LOWER_LIMIT_RST;
			cfg_q.auto_trigger_ms      <= AUTO_TRIG_RST;
			cfg_q.auto_up_block_ms     <= AUTO_BLOCK_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_UPPER_LIMIT: cfg_q.upper_position_limit <= pwdata[15:0];
				REG_LOWER_LIMIT: cfg_q.lower_position_limit <= pwdata[15:0];
				REG_AUTO_TRIG:   cfg_q.auto_trigger_ms      <= pwdata[15:0];
				default:         cfg_q.auto_up_block_ms     <= pwdata[15:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[3:2])
			REG_UPPER_LIMIT: prdata = {16'b0, cfg_q.upper_position_limit};
			REG_LOWER_LIMIT: prdata = {16'b0, cfg_q.lower_position_limit};
			REG_AUTO_TRIG:   prdata = {16'b0, cfg_q.auto_trigger_ms};
			default:         prdata = {16'b0, cfg_q.auto_up_block_ms};
		endcase
	end

endmodule

/* rtl/pwin_core.sv */
module pwin_core
	import pwin_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t       mode_q;
	mode_t       prior_q;
	logic [31:0] tick_q;
	logic [31:0] block_q;

	mode_t       cur;
	mode_t       tgt;
	mode_t       mode_nxt;
	mode_t       prior_nxt;
	mode_t       req;
	logic [31:0] cnt_nxt;
	logic [31:0] block_nxt;
	logic [31:0] since_block;
	logic        auto_ok;
	logic        blk_live;
	logic        is_tick;

	assign cur         = mode_q;
	assign is_tick     = (item.opcode == OP_TICK);
	assign req         = mode_decode(item.requested_state);
	assign cnt_nxt     = tick_q + TICK_STEP_MS;
	assign since_block = cnt_nxt - block_q;
	assign auto_ok     = item.learn_done && (item.press_time_ms >= cfg.auto_trigger_ms);
	assign blk_live    = (block_q != '0) && (since_block < {16'b0, cfg.auto_up_block_ms});

	// target state from tick rules or request
	always_comb begin
		tgt       = cur;
		block_nxt = block_q;
		if (!is_tick) begin
			if (legal_move(cur, req)) begin
				tgt = req;
			end
		end else begin
			unique case (cur)
				ST_UNINIT: tgt = ST_IDLE;
				ST_IDLE: begin
					if (item.button == BTN_UP) begin
						if (item.position < cfg.upper_position_limit) begin
							if (auto_ok) begin
								// expired block clears at the check
								if (blk_live) begin
									tgt = ST_MAN_UP;
								end else begin
									tgt       = ST_AUTO_UP;
									block_nxt = '0;
								end
							end else begin
								tgt = ST_MAN_UP;
							end
						end
					end else if (item.button == BTN_DOWN) begin
						if (item.position > cfg.lower_position_limit) begin
							tgt = auto_ok ? ST_AUTO_DN : ST_MAN_DN;
						end
					end
				end
				ST_MAN_UP: begin
					if (item.button == BTN_RELEASED ||
						item.position >= cfg.upper_position_limit) begin
						tgt = ST_IDLE;
					end
				end
				ST_MAN_DN: begin
					if (item.button == BTN_RELEASED ||
						item.position <= cfg.lower_position_limit) begin
						tgt = ST_IDLE;
					end
				end
				ST_AUTO_UP: begin
					if (item.button != BTN_RELEASED ||
						item.position >= cfg.upper_position_limit) begin
						tgt = ST_IDLE;
					end
				end
				ST_AUTO_DN: begin
					if (item.button != BTN_RELEASED ||
						item.position <= cfg.lower_position_limit) begin
						tgt = ST_IDLE;
					end
				end
				ST_PINCH: begin
					if (!item.pinch_active) begin
						tgt       = ST_IDLE;
						block_nxt = cnt_nxt;
					end
				end
				default: tgt = cur;
			endcase
		end
	end

	// tick transitions are always legal, requests were checked above
	always_comb begin
		mode_nxt  = mode_q;
		prior_nxt = prior_q;
		if (tgt != cur) begin
			mode_nxt  = tgt;
			prior_nxt = cur;
		end
	end

	// state update per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_UNINIT;
			prior_q <= ST_UNINIT;
			tick_q  <= '0;
			block_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_nxt;
			prior_q <= prior_nxt;
			if (is_tick) begin
				tick_q  <= cnt_nxt;
				block_q <= block_nxt;
			end
		end
	end

	// result fields
	assign res.mode            = mode_encode(mode_nxt);
	assign res.prior_mode      = mode_encode(prior_nxt);
	assign res.accepts_command = (mode_nxt == ST_IDLE);
	assign res.moving          = (mode_nxt == ST_MAN_UP) || (mode_nxt == ST_MAN_DN) ||
		(mode_nxt == ST_AUTO_UP) || (mode_nxt == ST_AUTO_DN) || (mode_nxt == ST_PINCH);

endmodule

/* rtl/power_window_mode_fsm.sv */
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      opcode .. requested_state
// result    out        result_valid / result_ready  mode, prior_mode, accepts_command, moving
// config    in         psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// one word per cycle unless a result waits untaken; a taken word goes through the input
// register, then the mode logic into the result register
// a result that is not taken holds the input register in place, and once that
// register is full too, item_ready drops until the result is drained
// reset puts the mode in uninit, clears the ms counter and the auto-up block
module power_window_mode_fsm
	import pwin_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        opcode,
	input  logic [1:0]  button,
	input  logic [15:0] position,
	input  logic [15:0] press_time_ms,
	input  logic        learn_done,
	input  logic        pinch_active,
	input  logic [2:0]  requested_state,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  mode,
	output logic [2:0]  prior_mode,
	output logic        accepts_command,
	output logic        moving,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;

	pwin_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline flow control
	assign advance    = !valid_s2 || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{opcode, button, position, press_time_ms,
				learn_done, pinch_active, requested_state};
		end
	end

	pwin_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign result_valid    = valid_s2;
	assign mode            = res_s2.mode;
	assign prior_mode      = res_s2.prior_mode;
	assign accepts_command = res_s2.accepts_command;
	assign moving          = res_s2.moving;

endmodule
